>>> hdl/sibo_pkg.sv
// Shared types and codes for the segmented index to block/offset mapper.
// No dependencies; used by the core in hdl/ and by the testbench.
package sibo_pkg;

	localparam int unsigned KIND_W = 2;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned IDX_W  = 22;
	localparam int unsigned NUM_W  = 6;
	localparam int unsigned OFF_W  = 16;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_BASE
	} fsm_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  block_length;
		logic [IDX_W-1:0]  flat_index;
	} cmd_t;

	typedef struct packed {
		logic [NUM_W-1:0]  block_number;
		logic [OFF_W-1:0]  block_offset;
		logic [IDX_W-1:0]  total_length;
		status_t           status;
	} rsp_t;

endpackage

>>> hdl/sibo_mem.sv
// Prefix-sum table storage: one write port, one read port, registered read data.
// No package dependencies.
module sibo_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/segmented_index_to_block_offset_core.sv
// Top level of the segmented index to block/offset mapper: command FSM,
// binary search over the prefix-sum table. Uses sibo_pkg and sibo_mem.
//
//  channel  | ports                    | transfer
//  ---------+--------------------------+------------------------------------
//  command  | start, busy, cmd         | rising edge with start=1, busy=0
//  result   | done, rsp                | every cycle with done=1
//
// Clear, append, nop and out-of-range lookups do not enter the search: the result
// strobes the cycle after the transfer, busy stays low.
// A lookup keeps busy high through the search: one table read per probe,
// then one read of the preceding entry. The table memory has a single
// read port, so these reads are issued one after another.
// arst_n clears block count, total and FSM; table contents stay undefined.
// The result side cannot stall; a result is shown for exactly one cycle.
module segmented_index_to_block_offset_core #(
	parameter int unsigned MAX_BLOCKS  = 64,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sibo_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output sibo_pkg::rsp_t  rsp
);

	localparam int unsigned AW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned IW = sibo_pkg::IDX_W;
	localparam int unsigned LW = sibo_pkg::LEN_W;
	localparam logic [LW-1:0] LEN_MASK = (LENGTH_BITS >= LW) ? {LW{1'b1}}
		: LW'((64'd1 << LENGTH_BITS) - 64'd1);

	sibo_pkg::fsm_state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] total_q, total_d;
	logic [AW-1:0] lo_q, hi_q, mid_q;
	logic          pend_q;
	logic [IW-1:0] idx_q;
	logic          done_q;
	sibo_pkg::rsp_t rsp_q, rsp_d;
	logic          rsp_load;

	logic          accept;
	logic [LW-1:0] len;
	logic [IW:0]   next_total;
	logic          full;
	logic          look_ok;

	logic [AW-1:0] lo_c, hi_c, mid_c;
	logic [AW:0]   span_sum;
	logic          more;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [IW-1:0] mem_rdata;

	logic [IW-1:0]       base;
	logic [IW-1:0]       off_full;
	logic [AW+sibo_pkg::NUM_W-1:0] num_wide;

	assign accept     = start && !busy;
	assign len        = cmd.block_length & LEN_MASK;
	assign next_total = {1'b0, total_q} + {{(IW+1-LW){1'b0}}, len};
	assign full       = (count_q == CW'(MAX_BLOCKS)) || next_total[IW];
	assign look_ok    = (count_q != '0) && (cmd.flat_index < total_q);

	// search step: fold in the probe read issued last cycle, pick next midpoint
	always_comb begin
		lo_c = lo_q;
		hi_c = hi_q;
		if (pend_q) begin
			if (mem_rdata > idx_q) begin
				hi_c = mid_q;
			end else begin
				lo_c = mid_q + 1'b1;
			end
		end
		more     = lo_c < hi_c;
		span_sum = {1'b0, lo_c} + {1'b0, hi_c};
		mid_c    = span_sum[AW:1];
	end

	assign base     = (lo_q == '0) ? '0 : mem_rdata;
	assign off_full = idx_q - base;
	assign num_wide = {{sibo_pkg::NUM_W{1'b0}}, lo_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sibo_pkg::FSM_IDLE: begin
				if (accept && cmd.kind == sibo_pkg::KIND_LOOKUP && look_ok) begin
					state_d = sibo_pkg::FSM_SEARCH;
				end
			end
			sibo_pkg::FSM_SEARCH: begin
				if (!more) begin
					state_d = sibo_pkg::FSM_BASE;
				end
			end
			sibo_pkg::FSM_BASE: begin
				state_d = sibo_pkg::FSM_IDLE;
			end
			default: begin
				state_d = sibo_pkg::FSM_IDLE;
			end
		endcase
	end

	// outputs: memory controls, table state updates, result data
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_re    = 1'b0;
		mem_raddr = mid_c;
		count_d   = count_q;
		total_d   = total_q;
		rsp_load  = 1'b0;
		rsp_d.block_number = '0;
		rsp_d.block_offset = '0;
		rsp_d.total_length = total_q;
		rsp_d.status       = sibo_pkg::STAT_OK;
		unique case (state_q)
			sibo_pkg::FSM_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						sibo_pkg::KIND_CLEAR: begin
							count_d  = '0;
							total_d  = '0;
							rsp_d.total_length = '0;
							rsp_load = 1'b1;
						end
						sibo_pkg::KIND_APPEND: begin
							if (full) begin
								rsp_d.status = sibo_pkg::STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + 1'b1;
								total_d = next_total[IW-1:0];
								rsp_d.total_length = next_total[IW-1:0];
							end
							rsp_load = 1'b1;
						end
						sibo_pkg::KIND_LOOKUP: begin
							if (!look_ok) begin
								rsp_d.status = sibo_pkg::STAT_RANGE;
								rsp_load     = 1'b1;
							end
						end
						sibo_pkg::KIND_NOP: begin
							rsp_load = 1'b1;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			sibo_pkg::FSM_SEARCH: begin
				mem_re = 1'b1;
				if (!more) begin
					// found block; fetch the preceding cumulative end
					mem_raddr = (lo_c == '0) ? '0 : lo_c - 1'b1;
				end
			end
			sibo_pkg::FSM_BASE: begin
				rsp_d.block_number = num_wide[sibo_pkg::NUM_W-1:0];
				rsp_d.block_offset = off_full[sibo_pkg::OFF_W-1:0];
				rsp_load           = 1'b1;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sibo_pkg::FSM_IDLE;
			count_q <= '0;
			total_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			total_q <= total_d;
			done_q  <= rsp_load;
			if (state_q == sibo_pkg::FSM_SEARCH) begin
				pend_q <= more;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cmd.flat_index;
			lo_q  <= '0;
			hi_q  <= AW'(count_q - 1'b1);
		end else if (state_q == sibo_pkg::FSM_SEARCH) begin
			lo_q  <= lo_c;
			hi_q  <= hi_c;
			mid_q <= mid_c;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	sibo_mem #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (IW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (next_total[IW-1:0]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy = (state_q != sibo_pkg::FSM_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind != sibo_pkg::KIND_LOOKUP) |=> done)
		else $error("non-lookup transfer did not produce a result next cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_BLOCKS))
		else $error("block count beyond table depth");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sibo_pkg::FSM_SEARCH) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == sibo_pkg::FSM_IDLE && !mem_re))
		else $error("table write overlapped a lookup");

	a_base_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sibo_pkg::FSM_BASE) |=> (done && !busy))
		else $error("lookup did not complete after base read");

endmodule

>>> test/segmented_index_to_block_offset_core_tb.sv
// Testbench for segmented_index_to_block_offset_core: directed and random
// clear/append/lookup commands, checked against an in-bench prefix-sum table.
// Depends on sibo_pkg and the core RTL in hdl/.
`timescale 1ns / 100ps

module segmented_index_to_block_offset_core_tb;

	localparam int unsigned MAX_BLOCKS = 64;
	localparam int unsigned N_ITEMS    = 1600;
	localparam int unsigned TAIL_ITEMS = 200;
	localparam int unsigned IDX_W      = sibo_pkg::IDX_W;
	localparam int unsigned LEN_W      = sibo_pkg::LEN_W;
	localparam int unsigned NUM_W      = sibo_pkg::NUM_W;
	localparam int unsigned OFF_W      = sibo_pkg::OFF_W;

	// Prefix-sum table mirror: predicts one result per accepted command.
	class sibo_scoreboard;
		logic [IDX_W-1:0] ends_tbl [MAX_BLOCKS];
		int unsigned      n_blocks;
		logic [IDX_W-1:0] total;
		sibo_pkg::rsp_t   pending [$];
		int unsigned      errors;
		int unsigned      n_cmds, n_hit, n_range, n_full;
		int unsigned      max_total, max_block;

		function new();
			n_blocks  = 0;
			total     = '0;
			errors    = 0;
			n_cmds    = 0;
			n_hit     = 0;
			n_range   = 0;
			n_full    = 0;
			max_total = 0;
			max_block = 0;
		endfunction

		function void note(sibo_pkg::cmd_t c);
			sibo_pkg::rsp_t   e;
			logic [IDX_W:0]   sum;
			logic [IDX_W-1:0] base;
			logic [IDX_W-1:0] diff;
			int unsigned      b;
			e = '0;
			n_cmds++;
			case (c.kind)
			sibo_pkg::KIND_CLEAR: begin
				n_blocks = 0;
				total    = '0;
			end
			sibo_pkg::KIND_APPEND: begin
				sum = {1'b0, total} + {{(IDX_W+1-LEN_W){1'b0}}, c.block_length};
				if (n_blocks >= MAX_BLOCKS || sum[IDX_W]) begin
					e.status = sibo_pkg::STAT_FULL;
					n_full++;
				end else begin
					total              = sum[IDX_W-1:0];
					ends_tbl[n_blocks] = total;
					n_blocks++;
				end
			end
			sibo_pkg::KIND_LOOKUP: begin
				if (n_blocks == 0 || c.flat_index >= total) begin
					e.status = sibo_pkg::STAT_RANGE;
					n_range++;
				end else begin
					// first block ending past the index; empty blocks fall through
					b = 0;
					while (ends_tbl[b] <= c.flat_index)
						b++;
					base           = (b > 0) ? ends_tbl[b-1] : '0;
					diff           = c.flat_index - base;
					e.block_number = b[NUM_W-1:0];
					e.block_offset = diff[OFF_W-1:0];
					n_hit++;
					if (b > max_block)
						max_block = b;
				end
			end
			default: ;
			endcase
			e.total_length = total;
			if (32'(total) > max_total)
				max_total = 32'(total);
			pending.push_back(e);
		endfunction

		function void check(sibo_pkg::rsp_t r);
			sibo_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: number %0d offset %0d total %0d status %0d",
					r.block_number, r.block_offset, r.total_length, r.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.block_number !== e.block_number) begin
				$error("block_number: expected %0d, got %0d", e.block_number, r.block_number);
				errors++;
			end
			if (r.block_offset !== e.block_offset) begin
				$error("block_offset: expected %0d, got %0d", e.block_offset, r.block_offset);
				errors++;
			end
			if (r.total_length !== e.total_length) begin
				$error("total_length: expected %0d, got %0d", e.total_length, r.total_length);
				errors++;
			end
			if (r.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, r.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	sibo_pkg::cmd_t cmd;
	logic busy;
	logic done;
	sibo_pkg::rsp_t rsp;

	sibo_scoreboard sb;

	// stimulus-side view of the table, used to aim lookups at boundaries
	int unsigned gen_total;
	int unsigned gen_ends [$];
	bit          no_gaps;
	int unsigned n_sent;

	segmented_index_to_block_offset_core #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.LENGTH_BITS(LEN_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(cmd);
			if (done !== 1'b0)
				sb.check(rsp);
		end
	end

	function automatic logic [LEN_W-1:0] pick_length(int unsigned style);
		case (style)
		0: return LEN_W'($urandom_range(0, 65535));
		1: return LEN_W'($urandom_range(0, 3));
		2: return '1;
		default: begin
			case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return LEN_W'($urandom_range(0, 65535));
			endcase
		end
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		int unsigned k;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (gen_ends.size() == 0 || sel == 0)
			return IDX_W'($urandom);
		k = $urandom_range(0, gen_ends.size() - 1);
		case (sel)
		1: return IDX_W'(gen_total);
		2: return IDX_W'(gen_total - 1);
		3: return IDX_W'(gen_ends[k]);
		4: return IDX_W'(gen_ends[k] - 1);
		default: return IDX_W'($urandom_range(0, gen_total - 1));
		endcase
	endfunction

	// Drives one command and returns at the edge where the transfer happens.
	task automatic send(sibo_pkg::kind_t k, logic [LEN_W-1:0] len,
		logic [IDX_W-1:0] idx);
		sibo_pkg::cmd_t c;
		c.kind         = k;
		c.block_length = len;
		c.flat_index   = idx;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		case (k)
		sibo_pkg::KIND_CLEAR: begin
			gen_total = 0;
			gen_ends.delete();
		end
		sibo_pkg::KIND_APPEND: begin
			if (gen_ends.size() < MAX_BLOCKS) begin
				gen_total += 32'(len);
				gen_ends.push_back(gen_total);
			end
		end
		default: ;
		endcase
		if (k != sibo_pkg::KIND_NOP)
			n_sent++;
	endtask

	initial begin
		int unsigned sel;
		int unsigned nblk;
		int unsigned style;
		int unsigned waited;
		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		gen_total = 0;
		n_sent    = 0;
		no_gaps   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, empty blocks, nop
		send(sibo_pkg::KIND_LOOKUP, '0, '0);
		send(sibo_pkg::KIND_LOOKUP, '1, '1);
		send(sibo_pkg::KIND_NOP, '1, '1);
		send(sibo_pkg::KIND_APPEND, '0, '0);
		send(sibo_pkg::KIND_APPEND, '1, '0);
		send(sibo_pkg::KIND_APPEND, 16'd1, '0);
		send(sibo_pkg::KIND_APPEND, '0, '0);
		send(sibo_pkg::KIND_APPEND, 16'd7, '0);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd0);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd65534);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd65535);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd65536);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd65542);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd65543);
		send(sibo_pkg::KIND_LOOKUP, '1, '1);
		send(sibo_pkg::KIND_NOP, '0, '0);
		send(sibo_pkg::KIND_CLEAR, '1, '1);
		send(sibo_pkg::KIND_LOOKUP, '0, '0);
		send(sibo_pkg::KIND_APPEND, 16'd5, '0);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd4);
		send(sibo_pkg::KIND_LOOKUP, '0, 22'd5);

		while (n_sent < N_ITEMS) begin
			sel     = $urandom_range(0, 9);
			no_gaps = (n_sent + TAIL_ITEMS >= N_ITEMS) || ($urandom_range(0, 3) == 0);
			if (sel <= 5) begin
				// fresh table, build it, then probe it
				send(sibo_pkg::KIND_CLEAR, LEN_W'($urandom), IDX_W'($urandom));
				nblk  = ($urandom_range(0, 3) == 0) ? $urandom_range(56, 70)
					: $urandom_range(0, 8);
				style = $urandom_range(0, 3);
				repeat (nblk)
					send(sibo_pkg::KIND_APPEND, pick_length(style), IDX_W'($urandom));
				repeat ($urandom_range(1, 12))
					send(sibo_pkg::KIND_LOOKUP, LEN_W'($urandom), pick_index());
			end else if (sel == 6) begin
				repeat ($urandom_range(1, 8))
					send(sibo_pkg::kind_t'($urandom_range(0, 3)),
						LEN_W'($urandom), IDX_W'($urandom));
			end else if (sel == 7) begin
				repeat ($urandom_range(1, 6))
					send(sibo_pkg::KIND_APPEND, pick_length($urandom_range(0, 3)),
						IDX_W'($urandom));
				repeat ($urandom_range(1, 6))
					send(sibo_pkg::KIND_LOOKUP, LEN_W'($urandom), pick_index());
			end else begin
				repeat ($urandom_range(1, 10))
					send(sibo_pkg::KIND_LOOKUP, LEN_W'($urandom), pick_index());
			end
		end
		start <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end

		$display("Checked %0d commands: %0d lookups mapped, %0d out of range, %0d full appends",
			sb.n_cmds, sb.n_hit, sb.n_range, sb.n_full);
		$display("Largest total length %0d, highest block number returned %0d",
			sb.max_total, sb.max_block);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
